@@ design/sbl_pkg.sv @@
// ----------------------------------------------------------------------------
// sbl_pkg
// Shared constants and types of the serial bootloader command parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sbl_pkg;

  // default page size in bytes
  localparam int PageBytesDef = 64;

  // command and protocol bytes
  localparam logic [7:0] CmdHandshake = 8'h01;
  localparam logic [7:0] CmdProgram   = 8'h02;
  localparam logic [7:0] CmdExit      = 8'h04;
  localparam logic [7:0] CmdLoad      = 8'h05;
  localparam logic [7:0] ByteEtx      = 8'h03;
  localparam logic [7:0] ByteAck      = 8'h06;
  localparam logic [7:0] ByteSafe     = 8'h09;

  // result kinds
  localparam logic [2:0] KindSend    = 3'd0;
  localparam logic [2:0] KindErase   = 3'd1;
  localparam logic [2:0] KindFill    = 3'd2;
  localparam logic [2:0] KindWrite   = 3'd3;
  localparam logic [2:0] KindRestart = 3'd4;

  // request to the shared adder
  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
  } alu_req_t;

  // response of the shared adder
  typedef struct packed {
    logic [15:0] sum;
    logic        zero;
  } alu_rsp_t;

endpackage

`default_nettype wire

@@ design/sbl_ram.sv @@
// ----------------------------------------------------------------------------
// sbl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

@@ design/sbl_alu.sv @@
// ----------------------------------------------------------------------------
// sbl_alu
// Shared 16-bit adder with zero detect, used for the byte countdown and for
// the fill word addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module sbl_alu
  import sbl_pkg::*;
(
  input  wire alu_req_t req_i,
  output alu_rsp_t      rsp_o
);

  logic [15:0] sum;

  // wrapping add and zero flag
  assign sum        = req_i.a + req_i.b;
  assign rsp_o.sum  = sum;
  assign rsp_o.zero = (sum == 16'h0000);

endmodule

`default_nettype wire

@@ design/serial_bootloader_command_parser.sv @@
// ----------------------------------------------------------------------------
// serial_bootloader_command_parser
// Parses bootloader commands from received serial bytes and issues host
// replies and flash operations.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / rx_byte_i) carries one received
//   byte per transfer. Output channel (out_valid_o / out_ready_i) carries one
//   result per transfer: kind, tx_byte, flash_address, flash_word, last.
//   last marks the final result caused by an input byte.
//   Order: a byte is taken in the idle state and parsed in the next cycle.
//   A completed program command runs a sequencer that emits ETX, erase,
//   PAGE_BYTES/2 (rounded up) fill words, write and ACK; each fill word
//   reads its two buffer bytes in turn through the one read port of the
//   page buffer RAM (states RdLo, RdHi, Fill). in_ready_o is low for the
//   whole run.
//   Reset puts the parser in idle with an empty page buffer; no clearing
//   pass is needed since unfilled buffer bytes read as zero by fill count.
//   When the receiver stalls, the output register holds its result and the
//   sequencer waits; no result is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_bootloader_command_parser
  import sbl_pkg::*;
#(
  parameter int PAGE_BYTES = PageBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       kind_o,
  output logic [7:0]       tx_byte_o,
  output logic [15:0]      flash_address_o,
  output logic [15:0]      flash_word_o,
  output logic             last_o
);

  localparam int IdxW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
  localparam int CntW = $clog2(PAGE_BYTES + 1);

  // sequencer states
  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StParse   = 4'd1;
  localparam logic [3:0] StEtx     = 4'd2;
  localparam logic [3:0] StErase   = 4'd3;
  localparam logic [3:0] StRdLo    = 4'd4;
  localparam logic [3:0] StRdHi    = 4'd5;
  localparam logic [3:0] StFill    = 4'd6;
  localparam logic [3:0] StWrite   = 4'd7;
  localparam logic [3:0] StAck     = 4'd8;
  localparam logic [3:0] StRestart = 4'd9;

  // parser phases
  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhSafe = 3'd1;
  localparam logic [2:0] PhAdrL = 3'd2;
  localparam logic [2:0] PhAdrH = 3'd3;
  localparam logic [2:0] PhLenL = 3'd4;
  localparam logic [2:0] PhLenH = 3'd5;
  localparam logic [2:0] PhData = 3'd6;

  // pending commands
  localparam logic [1:0] PendHandshake = 2'd0;
  localparam logic [1:0] PendLoad      = 2'd1;
  localparam logic [1:0] PendProgram   = 2'd2;
  localparam logic [1:0] PendExit      = 2'd3;

  logic [3:0]      state_q, state_d;
  logic [2:0]      phase_q, phase_d;
  logic [1:0]      pend_q, pend_d;
  logic [7:0]      held_q, held_d;
  logic [15:0]     page_addr_q, page_addr_d;
  logic [15:0]     rem_q, rem_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            exit_q, exit_d;
  logic [7:0]      rx_q, rx_d;
  logic [7:0]      lo_q, lo_d;

  logic            out_valid_q, out_valid_d;
  logic [2:0]      kind_q, kind_d;
  logic [7:0]      tx_q, tx_d;
  logic [15:0]     addr_q, addr_d;
  logic [15:0]     word_q, word_d;
  logic            last_q, last_d;

  logic            out_free;
  logic            emit;
  logic [CntW-1:0] hi_idx;
  logic [CntW:0]   idx_next_wide;
  logic            ram_we;
  logic            ram_re;
  logic [IdxW-1:0] ram_raddr;
  logic [7:0]      ram_rdata;
  alu_req_t        alu_req;
  alu_rsp_t        alu_rsp;

  // page buffer
  sbl_ram #(
    .Width (8),
    .Depth (PAGE_BYTES)
  ) u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (fill_q[IdxW-1:0]),
    .wr_data_i (rx_q),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  // shared adder
  sbl_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // adder operand select: countdown while parsing, word address otherwise
  always_comb begin
    if (state_q == StParse) begin
      alu_req.a = rem_q;
      alu_req.b = 16'hFFFF;
    end else begin
      alu_req.a = page_addr_q;
      alu_req.b = 16'(idx_q);
    end
  end

  assign out_free      = !out_valid_q || out_ready_i;
  assign hi_idx        = idx_q + CntW'(1);
  assign idx_next_wide = {1'b0, idx_q} + (CntW + 1)'(2);
  assign in_ready_o    = (state_q == StIdle);

  // sequencer and parser
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    pend_d      = pend_q;
    held_d      = held_q;
    page_addr_d = page_addr_q;
    rem_d       = rem_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    exit_d      = exit_q;
    rx_d        = rx_q;
    lo_d        = lo_q;
    emit        = 1'b0;
    kind_d      = KindSend;
    tx_d        = 8'h00;
    addr_d      = 16'h0000;
    word_d      = 16'h0000;
    last_d      = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = idx_q[IdxW-1:0];

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          rx_d    = rx_byte_i;
          state_d = StParse;
        end
      end

      StParse: begin
        state_d = StIdle;
        case (phase_q)
          PhIdle: begin
            if (rx_q == CmdHandshake) begin
              pend_d = PendHandshake; phase_d = PhSafe;
            end else if (rx_q == CmdLoad) begin
              pend_d = PendLoad; phase_d = PhSafe;
            end else if (rx_q == CmdProgram) begin
              pend_d = PendProgram; phase_d = PhSafe;
            end else if (rx_q == CmdExit) begin
              pend_d = PendExit; phase_d = PhSafe;
            end
          end
          PhSafe: begin
            phase_d = PhIdle;
            if (rx_q == ByteSafe) begin
              case (pend_q)
                PendHandshake: begin
                  exit_d  = 1'b0;
                  state_d = StAck;
                end
                PendLoad: phase_d = PhAdrL;
                PendProgram: begin
                  fill_d  = '0;
                  phase_d = PhLenL;
                end
                default: begin
                  // exit: command registers back to reset values, replies carry no state
                  exit_d      = 1'b1;
                  state_d     = StAck;
                  pend_d      = PendHandshake;
                  held_d      = 8'h00;
                  page_addr_d = 16'h0000;
                  rem_d       = 16'h0000;
                  fill_d      = '0;
                end
              endcase
            end
          end
          PhAdrL: begin
            held_d  = rx_q;
            phase_d = PhAdrH;
          end
          PhAdrH: begin
            page_addr_d = {rx_q, held_q};
            phase_d     = PhIdle;
            exit_d      = 1'b0;
            state_d     = StAck;
          end
          PhLenL: begin
            held_d  = rx_q;
            phase_d = PhLenH;
          end
          PhLenH: begin
            rem_d = {rx_q, held_q};
            if ({rx_q, held_q} == 16'h0000) begin
              phase_d = PhIdle;
              state_d = StEtx;
            end else begin
              phase_d = PhData;
            end
          end
          PhData: begin
            // bytes past the page end are counted but dropped
            if (fill_q < CntW'(PAGE_BYTES)) begin
              ram_we = 1'b1;
              fill_d = fill_q + CntW'(1);
            end
            rem_d = alu_rsp.sum;
            if (alu_rsp.zero) begin
              phase_d = PhIdle;
              state_d = StEtx;
            end
          end
          default: phase_d = PhIdle;
        endcase
      end

      StEtx: begin
        if (out_free) begin
          emit    = 1'b1;
          kind_d  = KindSend;
          tx_d    = ByteEtx;
          state_d = StErase;
        end
      end

      StErase: begin
        if (out_free) begin
          emit    = 1'b1;
          kind_d  = KindErase;
          addr_d  = page_addr_q;
          idx_d   = '0;
          state_d = StRdLo;
        end
      end

      StRdLo: begin
        ram_re  = 1'b1;
        state_d = StRdHi;
      end

      StRdHi: begin
        // low byte arrives, fetch the high byte
        lo_d      = (idx_q < fill_q) ? ram_rdata : 8'h00;
        ram_re    = 1'b1;
        ram_raddr = hi_idx[IdxW-1:0];
        state_d   = StFill;
      end

      StFill: begin
        if (out_free) begin
          emit   = 1'b1;
          kind_d = KindFill;
          addr_d = alu_rsp.sum;
          word_d = {(hi_idx < fill_q) ? ram_rdata : 8'h00, lo_q};
          idx_d  = idx_next_wide[CntW-1:0];
          if (idx_next_wide >= (CntW + 1)'(PAGE_BYTES)) begin
            state_d = StWrite;
          end else begin
            state_d = StRdLo;
          end
        end
      end

      StWrite: begin
        if (out_free) begin
          emit    = 1'b1;
          kind_d  = KindWrite;
          addr_d  = page_addr_q;
          exit_d  = 1'b0;
          state_d = StAck;
        end
      end

      StAck: begin
        if (out_free) begin
          emit    = 1'b1;
          kind_d  = KindSend;
          tx_d    = ByteAck;
          last_d  = !exit_q;
          state_d = exit_q ? StRestart : StIdle;
        end
      end

      StRestart: begin
        if (out_free) begin
          emit    = 1'b1;
          kind_d  = KindRestart;
          last_d  = 1'b1;
          exit_d  = 1'b0;
          state_d = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  // output register valid
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control and parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      phase_q     <= PhIdle;
      pend_q      <= PendHandshake;
      held_q      <= 8'h00;
      page_addr_q <= 16'h0000;
      rem_q       <= 16'h0000;
      fill_q      <= '0;
      idx_q       <= '0;
      exit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      pend_q      <= pend_d;
      held_q      <= held_d;
      page_addr_q <= page_addr_d;
      rem_q       <= rem_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      exit_q      <= exit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rx_q <= rx_d;
    lo_q <= lo_d;
    if (emit) begin
      kind_q <= kind_d;
      tx_q   <= tx_d;
      addr_q <= addr_d;
      word_q <= word_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign tx_byte_o       = tx_q;
  assign flash_address_o = addr_q;
  assign flash_word_o    = word_q;
  assign last_o          = last_q;

endmodule

`default_nettype wire
